### rtl/median3_adaptive_slew_current_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the median-of-three slew-limited current filter
// Both macros expect clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MEDIAN3_ADAPTIVE_SLEW_CURRENT_FILTER_CORE_MACROS_SVH
`define MEDIAN3_ADAPTIVE_SLEW_CURRENT_FILTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define M3SF_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("m3sf checker: property violated");

// Consequent must hold in the cycle after the antecedent
`define M3SF_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("m3sf checker: property violated");

`endif

### rtl/m3sf_pkg.sv
// ----------------------------------------------------------------------------
// m3sf_pkg
// Shared types and constants of the median-of-three current filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package m3sf_pkg;

	// Register map, index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_ALPHA_FAST = 3'd0,
		REG_ALPHA_SLOW = 3'd1,
		REG_BASE_STEP  = 3'd2,
		REG_REL_STEP   = 3'd3,
		REG_FAST_SCALE = 3'd4
	} reg_idx_t;

	localparam int unsigned PADDR_BITS = 5;

	localparam logic [15:0] ALPHA_FAST_RST = 16'd14418;
	localparam logic [15:0] ALPHA_SLOW_RST = 16'd3932;
	localparam logic [11:0] BASE_STEP_RST  = 12'd90;
	localparam logic [15:0] REL_STEP_RST   = 16'd5243;
	localparam logic [7:0]  FAST_SCALE_RST = 8'd40;

	typedef struct packed {
		logic [15:0] alpha_fast;
		logic [15:0] alpha_slow;
		logic [11:0] base_step;
		logic [15:0] rel_step;
		logic [7:0]  fast_step_scale;
	} cfg_t;

	// Back-end sequencer
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MAG  = 5'b00010,
		S_LIM  = 5'b00100,
		S_STEP = 5'b01000,
		S_DONE = 5'b10000
	} back_state_t;

endpackage

`default_nettype wire

### rtl/m3sf_stream_if.sv
// ----------------------------------------------------------------------------
// m3sf stream interfaces
// Valid/ready channels for raw samples and filtered results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface m3sf_sample_if #(parameter int W = 15);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;
	logic                boost;

	modport source (output valid, output sample, output boost, input ready);
	modport sink (input valid, input sample, input boost, output ready);
endinterface

interface m3sf_result_if #(parameter int W = 15);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] filtered_value;

	modport source (output valid, output filtered_value, input ready);
	modport sink (input valid, input filtered_value, output ready);
endinterface

`default_nettype wire

### rtl/m3sf_queue.sv
// ----------------------------------------------------------------------------
// m3sf_queue
// Two-entry FIFO between the front end and the back-end sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3sf_queue #(
	parameter int W = 17
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         pop,
	output logic [W-1:0]      rd_data,
	output logic              full,
	output logic              empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/m3sf_front.sv
// ----------------------------------------------------------------------------
// m3sf_front
// Accept samples, keep the rotating history, classify seed or tracking item
// and queue the median candidate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3sf_front #(
	parameter int SB = 15
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	m3sf_sample_if.sink   samples,
	input  wire logic     q_full,
	output logic          push,
	output logic [SB+1:0] entry
);

	logic signed [SB-1:0] hist_q [3];
	logic [1:0]           slot_q;
	logic                 seeded_q;

	logic signed [SB-1:0] h_new [3];
	logic signed [SB-1:0] mn_ab;
	logic signed [SB-1:0] mx_ab;
	logic signed [SB-1:0] mid_t;
	logic signed [SB-1:0] med;
	logic signed [SB-1:0] cand;

	assign samples.ready = ~q_full;
	assign push          = samples.valid & ~q_full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			h_new[i] = (slot_q == 2'(i)) ? samples.sample : hist_q[i];
		end
		mn_ab = (h_new[0] < h_new[1]) ? h_new[0] : h_new[1];
		mx_ab = (h_new[0] < h_new[1]) ? h_new[1] : h_new[0];
		mid_t = (mx_ab < h_new[2]) ? mx_ab : h_new[2];
		med   = (mn_ab > mid_t) ? mn_ab : mid_t;
		// the seed sample fills all three slots, so it is its own median
		cand  = seeded_q ? med : samples.sample;
	end

	// entry layout: seed flag, boost flag, candidate sample
	assign entry = {~seeded_q, samples.boost, cand};

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < 3; i++) begin
				hist_q[i] <= seeded_q ? h_new[i] : samples.sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= 2'd0;
			seeded_q <= 1'b0;
		end else if (push) begin
			seeded_q <= 1'b1;
			if (!seeded_q || slot_q >= 2'd2) begin
				slot_q <= 2'd0;
			end else begin
				slot_q <= slot_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/m3sf_back.sv
// ----------------------------------------------------------------------------
// m3sf_back
// Sequencer that limits the step, applies the weight, updates the level and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3sf_back #(
	parameter int SB = 15
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire m3sf_pkg::cfg_t cfg,
	input  wire logic [SB+1:0]  q_data,
	input  wire logic           q_empty,
	output logic                pop,
	m3sf_result_if.source       results
);

	localparam int LB     = SB + 8;
	localparam int LIM0_W = ((LB > 20) ? LB : 20) + 1;
	localparam int LIM_W  = LIM0_W + 4;
	localparam int CMP_W  = LIM_W + 1;
	localparam int PS_W   = LB + 18;
	localparam int INC_W  = PS_W + 1 - 16;
	localparam int SUM_W  = INC_W + 1;

	m3sf_pkg::back_state_t state_q;

	logic signed [SB-1:0]     cand_q;
	logic                     fast_q;
	logic                     seed_q;
	logic signed [LB-1:0]     level_q;
	logic [LB+15:0]           prodrel_q;
	logic signed [LB:0]       delta_q;
	logic [LIM0_W-1:0]        lim0_q;
	logic [LIM0_W+7:0]        prodfast_q;
	logic signed [PS_W-1:0]   prodstep_q;
	logic                     out_valid_q;
	logic signed [SB-1:0]     out_data_q;

	logic                     done_go;
	logic [LB-1:0]            mag;
	logic [LIM0_W-1:0]        lim0;
	logic [LIM_W-1:0]         limit;
	logic signed [CMP_W-1:0]  lim_s;
	logic signed [CMP_W-1:0]  lim_n;
	logic signed [CMP_W-1:0]  dlt_s;
	logic                     above;
	logic                     below;
	logic [15:0]              alpha;
	logic signed [LB:0]       step;
	logic signed [PS_W:0]     rnd;
	logic signed [INC_W-1:0]  inc;
	logic signed [SUM_W-1:0]  sum;
	logic signed [LB-1:0]     sat_level;
	logic signed [LB-1:0]     new_level;
	logic signed [LB:0]       rl;
	logic signed [SB:0]       rq;
	logic signed [SB-1:0]     result;

	assign done_go = ~out_valid_q | results.ready;
	assign pop     = ~q_empty &
		((state_q == m3sf_pkg::S_IDLE) | ((state_q == m3sf_pkg::S_DONE) & done_go));

	always_comb begin
		mag   = level_q[LB-1] ? (~level_q + 1'b1) : level_q;
		lim0  = LIM0_W'({cfg.base_step, 8'h00}) + LIM0_W'(prodrel_q[LB+15:16]);
		limit = fast_q ? prodfast_q[LIM0_W+7:4] : LIM_W'(lim0_q);
		lim_s = $signed({1'b0, limit});
		lim_n = -lim_s;
		dlt_s = CMP_W'(delta_q);
		above = dlt_s > lim_s;
		below = dlt_s < lim_n;
		alpha = (fast_q | ~(above | below)) ? cfg.alpha_fast : cfg.alpha_slow;
		// clamped step never exceeds |delta|, so the low bits carry it whole
		if (above) begin
			step = lim_s[LB:0];
		end else if (below) begin
			step = lim_n[LB:0];
		end else begin
			step = delta_q;
		end

		// round half up, then saturate the level to its width
		rnd = (PS_W + 1)'(prodstep_q) + (PS_W + 1)'(32768);
		inc = rnd[PS_W:16];
		sum = SUM_W'(inc) + SUM_W'(level_q);
		if (sum[SUM_W-1:LB-1] == {(SUM_W - LB + 1){sum[SUM_W-1]}}) begin
			sat_level = sum[LB-1:0];
		end else if (sum[SUM_W-1]) begin
			sat_level = {1'b1, {(LB - 1){1'b0}}};
		end else begin
			sat_level = {1'b0, {(LB - 1){1'b1}}};
		end
		new_level = seed_q ? $signed({cand_q, 8'h00}) : sat_level;

		rl = (LB + 1)'(new_level) + (LB + 1)'(128);
		rq = rl[LB:8];
		if (rq[SB] == rq[SB-1]) begin
			result = rq[SB-1:0];
		end else if (rq[SB]) begin
			result = {1'b1, {(SB - 1){1'b0}}};
		end else begin
			result = {1'b0, {(SB - 1){1'b1}}};
		end
	end

	assign results.valid          = out_valid_q;
	assign results.filtered_value = out_data_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			seed_q <= q_data[SB+1];
			fast_q <= q_data[SB];
			cand_q <= q_data[SB-1:0];
		end
		if (state_q == m3sf_pkg::S_MAG) begin
			prodrel_q <= (LB + 16)'(cfg.rel_step) * (LB + 16)'(mag);
			delta_q   <= $signed({cand_q[SB-1], cand_q, 8'h00}) - (LB + 1)'(level_q);
		end
		if (state_q == m3sf_pkg::S_LIM) begin
			lim0_q     <= lim0;
			prodfast_q <= (LIM0_W + 8)'(lim0) * (LIM0_W + 8)'(cfg.fast_step_scale);
		end
		if (state_q == m3sf_pkg::S_STEP) begin
			prodstep_q <= PS_W'($signed({1'b0, alpha})) * PS_W'(step);
		end
		if ((state_q == m3sf_pkg::S_DONE) && done_go) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= m3sf_pkg::S_IDLE;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load the output register as the sequencer finishes, drop it once taken
			if ((state_q == m3sf_pkg::S_DONE) && done_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				m3sf_pkg::S_IDLE: begin
					if (pop) begin
						state_q <= m3sf_pkg::S_MAG;
					end
				end
				m3sf_pkg::S_MAG:  state_q <= m3sf_pkg::S_LIM;
				m3sf_pkg::S_LIM:  state_q <= m3sf_pkg::S_STEP;
				m3sf_pkg::S_STEP: state_q <= m3sf_pkg::S_DONE;
				m3sf_pkg::S_DONE: begin
					if (done_go) begin
						level_q <= new_level;
						state_q <= pop ? m3sf_pkg::S_MAG : m3sf_pkg::S_IDLE;
					end
				end
				default: state_q <= m3sf_pkg::S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/median3_adaptive_slew_current_filter_core.sv
// A sample passes the queue, the sequencer and then the output register.
// The back-end sequencer takes a sample through four steps (magnitude, limit,
// weighted step, level update) and finishes it before it starts the next one.
// Up to two samples wait in the queue while the sequencer or output stalls.
// Reset (arst_n low, asynchronous): registers take their defaults, the level
// clears to zero and the next sample seeds the filter; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median3_adaptive_slew_current_filter_core
// Median-of-three, slew-limited exponential smoother for one current channel,
// with an APB-style register port.
// ----------------------------------------------------------------------------

module median3_adaptive_slew_current_filter_core #(
	parameter int SAMPLE_BITS = 15
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	m3sf_sample_if.sink                             samples,
	m3sf_result_if.source                           results,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [m3sf_pkg::PADDR_BITS-1:0]    paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);

	// queue entry: seed flag, fast-track flag, candidate sample
	localparam int QW = SAMPLE_BITS + 2;

	m3sf_pkg::cfg_t cfg_q;

	logic [2:0]    reg_idx;
	logic          wr_en;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic [QW-1:0] q_wr_data;
	logic [QW-1:0] q_rd_data;

	// Registers: one per word, index taken from paddr[4:2]; the port never waits
	assign pready  = 1'b1;
	assign reg_idx = paddr[m3sf_pkg::PADDR_BITS-1:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_fast      <= m3sf_pkg::ALPHA_FAST_RST;
			cfg_q.alpha_slow      <= m3sf_pkg::ALPHA_SLOW_RST;
			cfg_q.base_step       <= m3sf_pkg::BASE_STEP_RST;
			cfg_q.rel_step        <= m3sf_pkg::REL_STEP_RST;
			cfg_q.fast_step_scale <= m3sf_pkg::FAST_SCALE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				m3sf_pkg::REG_ALPHA_FAST: cfg_q.alpha_fast      <= pwdata[15:0];
				m3sf_pkg::REG_ALPHA_SLOW: cfg_q.alpha_slow      <= pwdata[15:0];
				m3sf_pkg::REG_BASE_STEP:  cfg_q.base_step       <= pwdata[11:0];
				m3sf_pkg::REG_REL_STEP:   cfg_q.rel_step        <= pwdata[15:0];
				m3sf_pkg::REG_FAST_SCALE: cfg_q.fast_step_scale <= pwdata[7:0];
				default: ; // drop writes to unmapped words
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			m3sf_pkg::REG_ALPHA_FAST: prdata = 32'(cfg_q.alpha_fast);
			m3sf_pkg::REG_ALPHA_SLOW: prdata = 32'(cfg_q.alpha_slow);
			m3sf_pkg::REG_BASE_STEP:  prdata = 32'(cfg_q.base_step);
			m3sf_pkg::REG_REL_STEP:   prdata = 32'(cfg_q.rel_step);
			m3sf_pkg::REG_FAST_SCALE: prdata = 32'(cfg_q.fast_step_scale);
			default:                  prdata = 32'd0;
		endcase
	end

	// Front end: accept, update history, work out the median candidate
	m3sf_front #(
		.SB(SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.q_full (q_full),
		.push   (q_push),
		.entry  (q_wr_data)
	);

	// Queue: decouple the front end from the sequencer
	m3sf_queue #(
		.W(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr_data),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end: slew limit, weighting, level update and output register
	m3sf_back #(
		.SB(SAMPLE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_data (q_rd_data),
		.q_empty(q_empty),
		.pop    (q_pop),
		.results(results)
	);

endmodule

`default_nettype wire

### rtl/m3sf_checker.sv
// ----------------------------------------------------------------------------
// m3sf_checker
// Port-level checks of the filter core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "median3_adaptive_slew_current_filter_core_macros.svh"

module m3sf_checker #(
	parameter int W = 15
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [W-1:0] out_data
);

	logic       in_acc;
	logic       out_acc;
	logic [3:0] pend_q;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// count transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else begin
			pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	`M3SF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`M3SF_ASSERT_NOW(a_no_invent, out_valid, pend_q != 4'd0)
	`M3SF_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= 4'd4)
	`M3SF_ASSERT_NOW(a_stall_full, !in_ready, pend_q >= 4'd2)
	`M3SF_ASSERT_NEXT(a_min_latency, in_acc && pend_q == 4'd0, !out_valid)

endmodule

bind median3_adaptive_slew_current_filter_core m3sf_checker #(
	.W(SAMPLE_BITS)
) u_m3sf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_data (results.filtered_value)
);

`default_nettype wire
